>>> rtl/core/half_period_frequency_meter_defines.svh
// assertion helpers for the half-period frequency meter
`ifndef HALF_PERIOD_FREQUENCY_METER_DEFINES_SVH
`define HALF_PERIOD_FREQUENCY_METER_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define HPFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold at a clock edge
`define HPFM_ASSERT_NEVER(lbl, cond, msg) \
  `HPFM_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/hpfm_pkg.sv
// ----------------------------------------------------------------------------
// hpfm_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package hpfm_pkg;

  parameter int unsigned TICKS_PER_SECOND = 1000000;
  parameter int unsigned PERIOD_WIDTH     = 20;

  parameter int unsigned FREQ_W   = 16;
  parameter int unsigned STATUS_W = 2;
  parameter int unsigned WAIT_W   = 17;
  parameter int unsigned CFG_IDX_W = 1;

  // quotient width covers the full tick rate
  parameter int unsigned QUOT_W = $clog2(TICKS_PER_SECOND + 1);
  parameter int unsigned CMP_W  = (QUOT_W > FREQ_W) ? QUOT_W : FREQ_W;
  parameter int unsigned DIVR_W = PERIOD_WIDTH + 1;
  parameter int unsigned REM_W  = PERIOD_WIDTH + 2;
  parameter int unsigned CNT_W  = $clog2(QUOT_W);

  parameter logic [STATUS_W-1:0] STATUS_VALID   = 2'd0;
  parameter logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd1;
  parameter logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  parameter logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 1'd0;
  parameter logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 1'd1;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_TIMEOUT,
    OUT_ZERO_PERIOD,
    OUT_QUOTIENT
  } out_sel_e;

  typedef struct packed {
    logic     arm;
    logic     wait_step;
    logic     first_edge;
    logic     meas_step;
    logic     div_start;
    logic     div_step;
    out_sel_e out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic edge_seen;
    logic timeout;
    logic period_zero;
    logic div_last;
  } dp_status_t;

endpackage

>>> rtl/core/half_period_frequency_meter.sv
// a timeout result is registered in the cycle after the tick that yields it
// the closing edge of a measurement starts the restoring divider
//   (one quotient bit per cycle); its result is registered once the output is free
// throughput: one tick per cycle while idle, waiting or measuring and the output is free
// reset: asynchronous active low; idle, min_frequency 0, max_frequency 65535
// ----------------------------------------------------------------------------
// half_period_frequency_meter
// measures the half period of a sampled pin and reports its frequency in hertz
// ----------------------------------------------------------------------------
module half_period_frequency_meter
  import hpfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tick transactions
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 start_req_i,
  input  logic                 pin_level_i,
  // result transactions
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FREQ_W-1:0]    frequency_o,
  output logic [STATUS_W-1:0]  status_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FREQ_W-1:0]    cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // register writes are taken on any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: start, first edge wait with timeout, half period count, divide
  hpfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (dp_status)
  );

  // counters, divider of TICKS_PER_SECOND by twice the half period, range check
  hpfm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .pin_level_i   (pin_level_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .frequency_o   (frequency_o),
    .status_code_o (status_o)
  );

endmodule

>>> rtl/core/hpfm_dpath.sv
// ----------------------------------------------------------------------------
// hpfm_dpath
// counters, config registers, restoring divider and result register
// ----------------------------------------------------------------------------
module hpfm_dpath
  import hpfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  logic                 pin_level_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FREQ_W-1:0]    cfg_data_i,
  output logic [FREQ_W-1:0]    frequency_o,
  output logic [STATUS_W-1:0]  status_code_o
);

  localparam logic [WAIT_W-1:0]       WAIT_MAX   = '1;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = '1;
  localparam logic [QUOT_W-1:0]       DIVIDEND   = QUOT_W'(TICKS_PER_SECOND);

  logic [FREQ_W-1:0]       min_freq_q, max_freq_q;
  logic                    ref_level_q;
  logic [WAIT_W-1:0]       wait_q, wait_inc;
  logic [PERIOD_WIDTH-1:0] period_q, period_inc;
  logic [DIVR_W-1:0]       divisor_q;
  logic [REM_W-1:0]        rem_q, rem_shift;
  logic [QUOT_W-1:0]       quot_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [CMP_W-1:0]        quot_ext;
  logic                    in_range;
  logic [FREQ_W-1:0]       freq_q;
  logic [STATUS_W-1:0]     code_q;

  // saturating counters
  assign wait_inc   = (wait_q == WAIT_MAX) ? wait_q : wait_q + 1'b1;
  assign period_inc = (period_q == PERIOD_MAX) ? period_q : period_q + 1'b1;

  assign rem_shift = {rem_q[REM_W-2:0], DIVIDEND[cnt_q]};
  assign quot_ext  = CMP_W'(quot_q);
  assign in_range  = (quot_ext >= CMP_W'(min_freq_q)) && (quot_ext <= CMP_W'(max_freq_q));

  assign status_o.edge_seen   = pin_level_i != ref_level_q;
  assign status_o.timeout     = wait_inc > WAIT_W'(max_freq_q);
  assign status_o.period_zero = period_inc == '0;
  assign status_o.div_last    = cnt_q == '0;

  // config and measurement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_freq_q  <= '0;
      max_freq_q  <= '1;
      ref_level_q <= 1'b0;
      wait_q      <= '0;
      period_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_FREQ: min_freq_q <= cfg_data_i;
          CFG_MAX_FREQ: max_freq_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.arm) begin
        ref_level_q <= pin_level_i;
        wait_q      <= '0;
        period_q    <= '0;
      end
      if (cmd_i.wait_step) wait_q <= wait_inc;
      if (cmd_i.first_edge) begin
        ref_level_q <= pin_level_i;
        period_q    <= '0;
      end
      if (cmd_i.meas_step) period_q <= period_inc;
    end
  end

  // restoring divider, one quotient bit per cycle, msb first
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      divisor_q <= {period_inc, 1'b0};
      rem_q     <= '0;
      quot_q    <= '0;
      cnt_q     <= CNT_W'(QUOT_W - 1);
    end else if (cmd_i.div_step) begin
      if (rem_shift >= REM_W'(divisor_q)) begin
        rem_q  <= rem_shift - REM_W'(divisor_q);
        quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_shift;
        quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.out_sel)
      OUT_TIMEOUT: begin
        freq_q <= '0;
        code_q <= STATUS_TIMEOUT;
      end
      OUT_ZERO_PERIOD: begin
        freq_q <= '0;
        code_q <= STATUS_RANGE;
      end
      OUT_QUOTIENT: begin
        freq_q <= in_range ? quot_ext[FREQ_W-1:0] : '0;
        code_q <= in_range ? STATUS_VALID : STATUS_RANGE;
      end
      default: ;
    endcase
  end

  assign frequency_o   = freq_q;
  assign status_code_o = code_q;

endmodule

>>> rtl/core/hpfm_ctrl.sv
// ----------------------------------------------------------------------------
// hpfm_ctrl
// measurement phase sequencer and result handshake
// ----------------------------------------------------------------------------
`include "half_period_frequency_meter_defines.svh"

module hpfm_ctrl
  import hpfm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       start_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_MEASURE,
    S_DIVIDE,
    S_DONE
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free, in_fire;
  ctrl_cmd_t cmd;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q != S_DIVIDE) && (state_q != S_DONE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cmd     = '0;
    cmd.out_sel = OUT_NONE;
    state_d = state_q;
    if (in_fire && start_req_i) begin
      cmd.arm = 1'b1;
      state_d = S_WAIT;
    end else begin
      case (state_q)
        S_WAIT: begin
          if (in_fire) begin
            if (status_i.edge_seen) begin
              cmd.first_edge = 1'b1;
              state_d        = S_MEASURE;
            end else begin
              cmd.wait_step = 1'b1;
              if (status_i.timeout) begin
                cmd.out_sel = OUT_TIMEOUT;
                state_d     = S_IDLE;
              end
            end
          end
        end
        S_MEASURE: begin
          if (in_fire) begin
            cmd.meas_step = 1'b1;
            if (status_i.edge_seen) begin
              if (status_i.period_zero) begin
                cmd.out_sel = OUT_ZERO_PERIOD;
                state_d     = S_IDLE;
              end else begin
                cmd.div_start = 1'b1;
                state_d       = S_DIVIDE;
              end
            end
          end
        end
        S_DIVIDE: begin
          cmd.div_step = 1'b1;
          if (status_i.div_last) state_d = S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            cmd.out_sel = OUT_QUOTIENT;
            state_d     = S_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_sel != OUT_NONE) out_valid_d = 1'b1;
    else if (out_ready_i)        out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  `HPFM_ASSERT_NEVER(a_no_input_while_dividing, (state_q == S_DIVIDE) && in_ready_o, "input taken during divide")
  `HPFM_ASSERT(a_no_result_overwrite, (cmd.out_sel != OUT_NONE) |-> out_free, "result register overwritten")
  `HPFM_ASSERT(a_divide_ends_in_done, (state_q == S_DIVIDE) && status_i.div_last |=> (state_q == S_DONE), "divide did not finish")
  `HPFM_ASSERT(a_done_when_free, (state_q == S_DONE) && out_free |=> out_valid_q && (state_q == S_IDLE), "quotient result not issued")

endmodule
